[hw/rtl/rbd_pkg.sv]
`default_nettype none
package rbd_pkg;

   localparam int BUFFER_DEPTH = 16;
   localparam int SEEN_DEPTH   = 64;

   localparam int CNT_W      = $clog2(BUFFER_DEPTH + 1);
   localparam int SEEN_CNT_W = $clog2(SEEN_DEPTH + 1);
   localparam int SEEN_IDX_W = $clog2(SEEN_DEPTH);

   localparam int ID_W      = 64;
   localparam int SEQ_W     = 16;
   localparam int PAYLOAD_W = 32;
   localparam int STATUS_W  = 3;

   localparam logic [SEQ_W-1:0] FIRST_POSITION = SEQ_W'(1);
   localparam logic [SEQ_W-1:0] MAX_POSITION   = {SEQ_W{1'b1}};

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_POP    = 2'd1,
      MODE_QUERY  = 2'd2,
      MODE_STATUS = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DUPLICATE = 3'd1,
      STAT_BUF_FULL  = 3'd2,
      STAT_IDS_FULL  = 3'd3,
      STAT_POP_EMPTY = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic search_step;
      logic execute;
   } cmd_type;

   typedef struct packed {
      logic is_insert;
      logic search_done;
   } stat_type;

endpackage
`default_nettype wire

[hw/rtl/rbd_if.sv]
`default_nettype none
interface rbd_req_if;
   import rbd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [1:0]           mode;
   logic [ID_W-1:0]      item_id;
   logic [SEQ_W-1:0]     seq_num;
   logic                 item_kind;
   logic [PAYLOAD_W-1:0] payload_in;
   modport source (output valid, mode, item_id, seq_num, item_kind, payload_in,
                   input ready);
   modport sink   (input valid, mode, item_id, seq_num, item_kind, payload_in,
                   output ready);
endinterface

interface rbd_rsp_if;
   import rbd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [PAYLOAD_W-1:0] payload_out;
   logic                 kind_out;
   logic                 found;
   logic                 next_available;
   logic                 task_done;
   logic [SEQ_W-1:0]     expected_position;
   logic [CNT_W-1:0]     held_count;
   logic [STATUS_W-1:0]  status;
   modport source (output valid, payload_out, kind_out, found, next_available, task_done,
                   expected_position, held_count, status, input ready);
   modport sink   (input valid, payload_out, kind_out, found, next_available, task_done,
                   expected_position, held_count, status, output ready);
endinterface

interface rbd_csr_if;
   import rbd_pkg::*;
   logic             valid;
   logic             ready;
   logic [SEQ_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/rbd_ctrl.sv]
`default_nettype none
module rbd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire rbd_pkg::stat_type stat,
   output rbd_pkg::cmd_type      cmd
);
   import rbd_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (!stat.is_insert || stat.search_done) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait for a free result register
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.execute | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hw/rtl/rbd_datapath.sv]
`default_nettype none
module rbd_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rbd_pkg::cmd_type               cmd,
   output rbd_pkg::stat_type                   stat,
   input  wire logic [1:0]                     req_mode,
   input  wire logic [rbd_pkg::ID_W-1:0]       req_item_id,
   input  wire logic [rbd_pkg::SEQ_W-1:0]      req_seq_num,
   input  wire logic                           req_item_kind,
   input  wire logic [rbd_pkg::PAYLOAD_W-1:0]  req_payload_in,
   input  wire logic                           csr_write,
   input  wire logic [rbd_pkg::SEQ_W-1:0]      csr_data,
   output logic [rbd_pkg::PAYLOAD_W-1:0]       rsp_payload_out,
   output logic                                rsp_kind_out,
   output logic                                rsp_found,
   output logic                                rsp_next_available,
   output logic                                rsp_task_done,
   output logic [rbd_pkg::SEQ_W-1:0]           rsp_expected_position,
   output logic [rbd_pkg::CNT_W-1:0]           rsp_held_count,
   output logic [rbd_pkg::STATUS_W-1:0]        rsp_status
);
   import rbd_pkg::*;

   // captured request
   mode_type             mode_ff;
   logic [ID_W-1:0]      id_ff;
   logic [SEQ_W-1:0]     seq_ff;
   logic                 kind_ff;
   logic [PAYLOAD_W-1:0] pay_ff;

   // sorted entry lanes
   logic [SEQ_W-1:0]     e_seq_ff [BUFFER_DEPTH];
   logic [PAYLOAD_W-1:0] e_pay_ff [BUFFER_DEPTH];
   logic                 e_kind_ff[BUFFER_DEPTH];
   logic [SEQ_W-1:0]     e_seq_in [BUFFER_DEPTH];
   logic [PAYLOAD_W-1:0] e_pay_in [BUFFER_DEPTH];
   logic                 e_kind_in[BUFFER_DEPTH];
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [SEQ_W-1:0]     pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic [SEQ_W-1:0]     task_len_ff;

   // seen-id store and its scan
   logic [ID_W-1:0]       seen_mem[SEEN_DEPTH];
   logic [ID_W-1:0]       rd_data_ff;
   logic [SEEN_CNT_W-1:0] seen_cnt_ff;
   logic [SEEN_CNT_W-1:0] scan_ff;
   logic                  cmp_vld_ff;
   logic                  hit_ff;
   logic                  scan_more;

   // combinational results
   logic [BUFFER_DEPTH-1:0] le;
   logic [CNT_W-1:0]        slot;
   logic                    q_found;
   logic [PAYLOAD_W-1:0]    q_pay;
   logic                    q_kind;
   logic                    insert_ok, pop_ok;
   status_type              status_in;
   logic [PAYLOAD_W-1:0]    res_pay;
   logic                    res_kind, res_found;

   assign scan_more        = scan_ff < seen_cnt_ff;
   assign stat.is_insert   = (mode_ff == MODE_INSERT);
   assign stat.search_done = !scan_more && !cmp_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         id_ff   <= req_item_id;
         seq_ff  <= req_seq_num;
         kind_ff <= req_item_kind;
         pay_ff  <= req_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= seen_mem[scan_ff[SEEN_IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && insert_ok) begin
         seen_mem[seen_cnt_ff[SEEN_IDX_W-1:0]] <= id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (cmd.capture) begin
         scan_ff    <= '0;
         cmp_vld_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (cmd.search_step) begin
         cmp_vld_ff <= scan_more;
         if (scan_more) begin
            scan_ff <= scan_ff + SEEN_CNT_W'(1);
         end
         if (cmp_vld_ff && rd_data_ff == id_ff) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         le[i] = (CNT_W'(i) < cnt_ff) && (e_seq_ff[i] <= seq_ff);
      end
      slot = cnt_ff;
      for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
         if (!le[i]) begin
            slot = CNT_W'(i);
         end
      end

      q_found = 1'b0;
      q_pay   = '0;
      q_kind  = 1'b0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         if (CNT_W'(i) < cnt_ff && e_seq_ff[i] == seq_ff) begin
            q_found = 1'b1;
            q_pay   = e_pay_ff[i];
            q_kind  = e_kind_ff[i];
         end
      end

      insert_ok = 1'b0;
      pop_ok    = 1'b0;
      status_in = STAT_OK;
      res_pay   = '0;
      res_kind  = 1'b0;
      res_found = 1'b0;
      case (mode_ff)
         MODE_INSERT: begin
            if (hit_ff) begin
               status_in = STAT_DUPLICATE;
            end else if (cnt_ff >= CNT_W'(BUFFER_DEPTH)) begin
               status_in = STAT_BUF_FULL;
            end else if (seen_cnt_ff >= SEEN_CNT_W'(SEEN_DEPTH)) begin
               status_in = STAT_IDS_FULL;
            end else begin
               insert_ok = 1'b1;
            end
         end
         MODE_POP: begin
            if (cnt_ff == '0) begin
               status_in = STAT_POP_EMPTY;
            end else begin
               pop_ok    = 1'b1;
               res_pay   = e_pay_ff[0];
               res_kind  = e_kind_ff[0];
               res_found = 1'b1;
            end
         end
         MODE_QUERY: begin
            res_pay   = q_pay;
            res_kind  = q_kind;
            res_found = q_found;
         end
         default: ;
      endcase

      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         e_seq_in[i]  = e_seq_ff[i];
         e_pay_in[i]  = e_pay_ff[i];
         e_kind_in[i] = e_kind_ff[i];
         if (insert_ok) begin
            if (CNT_W'(i) == slot) begin
               e_seq_in[i]  = seq_ff;
               e_pay_in[i]  = pay_ff;
               e_kind_in[i] = kind_ff;
            end else if (CNT_W'(i) > slot && i > 0) begin
               e_seq_in[i]  = e_seq_ff[(i > 0) ? i - 1 : 0];
               e_pay_in[i]  = e_pay_ff[(i > 0) ? i - 1 : 0];
               e_kind_in[i] = e_kind_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (pop_ok && i < BUFFER_DEPTH - 1) begin
            e_seq_in[i]  = e_seq_ff[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
            e_pay_in[i]  = e_pay_ff[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
            e_kind_in[i] = e_kind_ff[(i < BUFFER_DEPTH - 1) ? i + 1 : i];
         end
      end

      cnt_in = cnt_ff;
      if (insert_ok) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop_ok) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end

      pos_in = pos_ff;
      if (pop_ok && pos_ff != MAX_POSITION) begin
         pos_in = pos_ff + SEQ_W'(1);
      end

      done_in = done_ff |
                ({1'b0, pos_in} >= ({1'b0, task_len_ff} + (SEQ_W + 1)'(1)));
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < BUFFER_DEPTH; i++) begin
            e_seq_ff[i]  <= e_seq_in[i];
            e_pay_ff[i]  <= e_pay_in[i];
            e_kind_ff[i] <= e_kind_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         seen_cnt_ff <= '0;
         pos_ff      <= FIRST_POSITION;
         done_ff     <= 1'b0;
         task_len_ff <= '0;
      end else if (cmd.execute) begin
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         done_ff <= done_in;
         if (insert_ok) begin
            seen_cnt_ff <= seen_cnt_ff + SEEN_CNT_W'(1);
         end
      end else if (csr_write) begin
         task_len_ff <= csr_data;
         done_ff     <= done_ff |
                        ({1'b0, pos_ff} >= ({1'b0, csr_data} + (SEQ_W + 1)'(1)));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_payload_out       <= res_pay;
         rsp_kind_out          <= res_kind;
         rsp_found             <= res_found;
         rsp_next_available    <= (cnt_in != '0) && (e_seq_in[0] == pos_in);
         rsp_task_done         <= done_in;
         rsp_expected_position <= pos_in;
         rsp_held_count        <= cnt_in;
         rsp_status            <= status_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/resequencing_buffer_dedup.sv]
`default_nettype none
// Resequencing buffer with duplicate-id rejection.
// Channels: req_bus carries one command beat (mode, item_id, seq_num,
// item_kind, payload_in); rsp_bus returns exactly one result beat per command;
// csr_bus writes task_length at any time the block is idle.
// Modes: insert keeps entries sorted by sequence number (equal numbers keep
// arrival order), pop removes the head and advances the expected position,
// query returns the last held entry with a matching number, status reports only.
// Flow: a command is taken, then for an insert the seen-id memory is scanned
// one entry per cycle with a registered read, then the result is computed and
// registered once the result register is free. Pop, query and status do not
// wait for the scan. The next command is taken once the control is back in idle
// after the result is registered; commands are handled one at a time.
// The result register lets the next command be taken while a result waits;
// when the receiver stalls, the following result holds in the execute step.
// Reset (synchronous, active high) empties the buffer and the id store, sets
// the expected position to one, clears task_length and the done latch. No
// clearing pass is needed: the id store is tracked by its fill count.
module resequencing_buffer_dedup (
   input wire logic clock,
   input wire logic reset,
   rbd_req_if.sink   req_bus,
   rbd_rsp_if.source rsp_bus,
   rbd_csr_if.sink   csr_bus
);
   import rbd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // register write is always accepted; it is ignored if it meets a command's execute step
   assign csr_bus.ready = 1'b1;

   rbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rbd_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_mode              (req_bus.mode),
      .req_item_id           (req_bus.item_id),
      .req_seq_num           (req_bus.seq_num),
      .req_item_kind         (req_bus.item_kind),
      .req_payload_in        (req_bus.payload_in),
      .csr_write             (csr_bus.valid),
      .csr_data              (csr_bus.data),
      .rsp_payload_out       (rsp_bus.payload_out),
      .rsp_kind_out          (rsp_bus.kind_out),
      .rsp_found             (rsp_bus.found),
      .rsp_next_available    (rsp_bus.next_available),
      .rsp_task_done         (rsp_bus.task_done),
      .rsp_expected_position (rsp_bus.expected_position),
      .rsp_held_count        (rsp_bus.held_count),
      .rsp_status            (rsp_bus.status)
   );

endmodule
`default_nettype wire

[hw/rtl/rbd_checker.sv]
`default_nettype none
module rbd_sva (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic                          rsp_found,
   input wire logic                          rsp_task_done,
   input wire logic [rbd_pkg::CNT_W-1:0]     rsp_held_count,
   input wire logic [rbd_pkg::STATUS_W-1:0]  rsp_status
);
   import rbd_pkg::*;

   logic done_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         done_seen_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_task_done) begin
         done_seen_ff <= 1'b1;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_done_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && done_seen_ff |-> rsp_task_done)
      else $error("task_done fell without reset");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_status == STAT_OK)
      else $error("found with error status");

   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_POP_EMPTY |-> rsp_held_count == '0)
      else $error("pop on empty with entries held");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_held_count <= CNT_W'(BUFFER_DEPTH))
      else $error("held_count above depth");

endmodule

bind resequencing_buffer_dedup rbd_sva u_rbd_sva (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_found      (rsp_bus.found),
   .rsp_task_done  (rsp_bus.task_done),
   .rsp_held_count (rsp_bus.held_count),
   .rsp_status     (rsp_bus.status)
);
`default_nettype wire

[tb/rbd_checker.sv]
`default_nettype none
module rbd_checker
   import rbd_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   rbd_req_if.sink   req_mon,
   rbd_rsp_if.sink   rsp_mon,
   rbd_csr_if.sink   csr_mon,
   output int        error_count,
   output int        pending
);

   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload_out;
      logic                 kind_out;
      logic                 found;
      logic                 next_available;
      logic                 task_done;
      logic [SEQ_W-1:0]     expected_position;
      logic [CNT_W-1:0]     held_count;
      logic [STATUS_W-1:0]  status;
   } result_type;

   result_type           result_queue[$];
   logic [SEQ_W-1:0]     task_len;
   logic [SEQ_W-1:0]     held_seq[BUFFER_DEPTH];
   logic [PAYLOAD_W-1:0] held_payload[BUFFER_DEPTH];
   logic                 held_kind[BUFFER_DEPTH];
   int                   held_num;
   logic [ID_W-1:0]      seen_list[$];
   logic [SEQ_W-1:0]     exp_pos;
   logic                 done_flag;

   assign pending = result_queue.size();

   function automatic void update_done();
      if (32'(exp_pos) >= 32'(task_len) + 1) done_flag = 1'b1;
   endfunction

   function automatic result_type predict_beat(logic [1:0] mode, logic [ID_W-1:0] id,
         logic [SEQ_W-1:0] seq, logic kind, logic [PAYLOAD_W-1:0] pay);
      result_type r;
      int slot;
      logic dup;
      r = '0;
      r.status = STAT_OK;
      dup = 1'b0;
      case (mode)
         MODE_INSERT: begin
            foreach (seen_list[i]) if (seen_list[i] == id) dup = 1'b1;
            if (dup) r.status = STAT_DUPLICATE;
            else if (held_num >= BUFFER_DEPTH) r.status = STAT_BUF_FULL;
            else if (seen_list.size() >= SEEN_DEPTH) r.status = STAT_IDS_FULL;
            else begin
               slot = 0;
               while (slot < held_num && held_seq[slot] <= seq) slot++;
               for (int i = held_num; i > slot; i--) begin
                  held_seq[i] = held_seq[i-1];
                  held_payload[i] = held_payload[i-1];
                  held_kind[i] = held_kind[i-1];
               end
               held_seq[slot] = seq;
               held_payload[slot] = pay;
               held_kind[slot] = kind;
               held_num++;
               seen_list.push_back(id);
            end
         end
         MODE_POP: begin
            if (held_num == 0) r.status = STAT_POP_EMPTY;
            else begin
               r.payload_out = held_payload[0];
               r.kind_out = held_kind[0];
               r.found = 1'b1;
               for (int i = 1; i < held_num; i++) begin
                  held_seq[i-1] = held_seq[i];
                  held_payload[i-1] = held_payload[i];
                  held_kind[i-1] = held_kind[i];
               end
               held_num--;
               if (exp_pos != MAX_POSITION) exp_pos++;
            end
         end
         MODE_QUERY: begin
            for (int i = 0; i < held_num; i++)
               if (held_seq[i] == seq) begin
                  r.payload_out = held_payload[i];
                  r.kind_out = held_kind[i];
                  r.found = 1'b1;
               end
         end
         default: ;
      endcase
      update_done();
      r.next_available = (held_num > 0) && (held_seq[0] == exp_pos);
      r.task_done = done_flag;
      r.expected_position = exp_pos;
      r.held_count = CNT_W'(held_num);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         task_len = '0;
         held_num = 0;
         seen_list.delete();
         exp_pos = FIRST_POSITION;
         done_flag = 1'b0;
         result_queue.delete();
         error_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            task_len = csr_mon.data;
            update_done();
         end
         // predict the accepted command beat
         if (req_mon.valid && req_mon.ready)
            result_queue.push_back(predict_beat(req_mon.mode, req_mon.item_id,
               req_mon.seq_num, req_mon.item_kind, req_mon.payload_in));
         // compare the result beat with the oldest prediction
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (result_queue.size() == 0)
               report_mismatch("unexpected beat", rsp_mon.status, 0);
            else begin
               want = result_queue[0];
               result_queue.delete(0);
               if (rsp_mon.payload_out !== want.payload_out)
                  report_mismatch("payload_out", rsp_mon.payload_out, want.payload_out);
               if (rsp_mon.kind_out !== want.kind_out)
                  report_mismatch("kind_out", rsp_mon.kind_out, want.kind_out);
               if (rsp_mon.found !== want.found)
                  report_mismatch("found", rsp_mon.found, want.found);
               if (rsp_mon.next_available !== want.next_available)
                  report_mismatch("next_available", rsp_mon.next_available,
                     want.next_available);
               if (rsp_mon.task_done !== want.task_done)
                  report_mismatch("task_done", rsp_mon.task_done, want.task_done);
               if (rsp_mon.expected_position !== want.expected_position)
                  report_mismatch("expected_position", rsp_mon.expected_position,
                     want.expected_position);
               if (rsp_mon.held_count !== want.held_count)
                  report_mismatch("held_count", rsp_mon.held_count, want.held_count);
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
            end
         end
      end
   end

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
   import rbd_pkg::*;

   localparam int CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   int   cycle_count;
   int   error_count;
   int   pending;
   int   send_idle_pct;
   int   recv_stall_pct;
   logic [ID_W-1:0] id_pool[$];

   rbd_req_if req_bus();
   rbd_rsp_if rsp_bus();
   rbd_csr_if csr_bus();

   resequencing_buffer_dedup i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   rbd_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus.sink),
      .rsp_mon     (rsp_bus.sink),
      .csr_mon     (csr_bus.sink),
      .error_count (error_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort on a hang; far beyond the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Receiver: stall at random per the current phase.
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Send one command beat; idle at random first, then hold until accepted.
   task automatic send_beat(logic [1:0] mode, logic [ID_W-1:0] id,
         logic [SEQ_W-1:0] seq, logic kind, logic [PAYLOAD_W-1:0] pay);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= mode;
      req_bus.item_id    <= id;
      req_bus.seq_num    <= seq;
      req_bus.item_kind  <= kind;
      req_bus.payload_in <= pay;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all results, allow the block to settle, then write task_length.
   task automatic write_length(logic [SEQ_W-1:0] len);
      drop_valid();
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= len;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Hardware resets the id store only at reset; fresh ids run out at 64.
   function automatic logic [ID_W-1:0] fresh_id();
      logic [ID_W-1:0] id;
      id = {$urandom, $urandom};
      id_pool.push_back(id);
      return id;
   endfunction

   function automatic logic [ID_W-1:0] old_id();
      if (id_pool.size() == 0) return '0;
      return id_pool[$urandom_range(id_pool.size() - 1)];
   endfunction

   // Mostly well-formed traffic: inserts near a base number, pops, queries and status beats.
   task automatic random_beats(int count, logic [SEQ_W-1:0] base);
      int pick;
      logic [ID_W-1:0] id;
      logic [SEQ_W-1:0] seq;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         seq = base + SEQ_W'($urandom_range(40));
         if ($urandom_range(19) == 0) seq = SEQ_W'($urandom);
         if (pick < 45) begin
            id = ($urandom_range(9) == 0) ? old_id() : fresh_id();
            send_beat(MODE_INSERT, id, seq, 1'($urandom), $urandom);
         end else if (pick < 75) begin
            send_beat(MODE_POP, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom),
               $urandom);
         end else if (pick < 92) begin
            send_beat(MODE_QUERY, {$urandom, $urandom}, seq, 1'($urandom), $urandom);
         end else begin
            send_beat(MODE_STATUS, {$urandom, $urandom}, SEQ_W'($urandom), 1'($urandom),
               $urandom);
         end
      end
   endtask

   initial begin
      cycle_count            = 0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      req_bus.valid          = 1'b0;
      req_bus.mode           = MODE_STATUS;
      req_bus.item_id        = '0;
      req_bus.seq_num        = '0;
      req_bus.item_kind      = 1'b0;
      req_bus.payload_in     = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.data           = '0;
      reset                  = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty pop, no-match query, status, field extremes.
      write_length(SEQ_W'(3));
      send_beat(MODE_POP, '0, '0, 1'b0, '0);
      send_beat(MODE_QUERY, '1, '1, 1'b1, '1);
      send_beat(MODE_STATUS, '0, '0, 1'b0, '0);
      send_beat(MODE_INSERT, '1, SEQ_W'(2), 1'b1, '1);
      send_beat(MODE_INSERT, '0, SEQ_W'(1), 1'b0, '0);
      send_beat(MODE_INSERT, ID_W'(5), SEQ_W'(2), 1'b0, 32'h1234_5678);  // equal seq
      send_beat(MODE_INSERT, '1, SEQ_W'(7), 1'b0, '0);                   // duplicate
      send_beat(MODE_INSERT, ID_W'(6), '1, 1'b1, 32'hA5A5_5A5A);
      send_beat(MODE_QUERY, '0, SEQ_W'(2), 1'b0, '0);                     // last match
      send_beat(MODE_QUERY, '0, '1, 1'b0, '0);
      repeat (4) send_beat(MODE_POP, '0, '0, 1'b0, '0);                  // reach done
      send_beat(MODE_POP, '0, '0, 1'b0, '0);
      id_pool.push_back('0);
      id_pool.push_back('1);
      id_pool.push_back(ID_W'(5));
      id_pool.push_back(ID_W'(6));
      // Fill the buffer, then one more new id.
      for (int i = 0; i < 17; i++)
         send_beat(MODE_INSERT, fresh_id(), SEQ_W'(i + 5), 1'($urandom), $urandom);
      write_length('0);

      // Random phases with different idling and lengths.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 53) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 53) : 0;
         random_beats(300, SEQ_W'(5 + ph * 2));
         write_length((ph == 2) ? SEQ_W'(65534) : SEQ_W'($urandom_range(2, 40)));
      end

      // Id store is full now; keep stressing pops, queries and rejected inserts.
      send_idle_pct  = 10;
      recv_stall_pct = 10;
      random_beats(600, SEQ_W'(10));
      drop_valid();

      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
